FILE: design/rhm_pkg.sv
`timescale 1ns / 1ps
// rhm_pkg: request types, register indexes, modular constants and fold tables
// for the rolling hash match block; depends on nothing else
package rhm_pkg;

    localparam int HASH_W      = 30;
    localparam int SUM_W       = 33;
    localparam int CHUNK_W     = 6;
    localparam int CHUNK_N     = 64;
    localparam int BASE_CHUNKS = 6;
    localparam int FOLD_CHUNKS = 7;
    localparam int PROD_W      = FOLD_CHUNKS * CHUNK_W;
    localparam int HX_W        = BASE_CHUNKS * CHUNK_W;
    localparam int FOLD_STEPS  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 30;
    localparam int LEN_FIELD_W = 6;

    localparam logic [HASH_W-1:0] HASH_MOD  = 30'd1000000007;
    localparam logic [HASH_W-1:0] HASH_BASE = 30'd7919;
    localparam logic [SUM_W-1:0]  MOD_S     = SUM_W'(HASH_MOD);
    localparam logic [63:0]       MOD64     = 64'(HASH_MOD);
    localparam logic [63:0]       BASE64    = 64'(HASH_BASE);

    localparam logic [7:0] BYTE_BIAS = 8'd96;
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_Z    = 8'h7a;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    localparam logic [SUM_W-1:0] MOD_LESS_BIAS = MOD_S - SUM_W'(BYTE_BIAS);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN_HASH   = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_LENGTH = 2'd1;
    localparam t_cfg_idx CFG_TOP_POWER      = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_req;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [7:0] emit_byte;
        logic       shift_out;
        logic       win_full;
        logic       emit;
        logic       last;
    } t_side;

    typedef logic [BASE_CHUNKS-1:0][CHUNK_N-1:0][HASH_W-1:0] t_base_tab;
    typedef logic [FOLD_CHUNKS-1:0][CHUNK_N-1:0][HASH_W-1:0] t_fold_tab;

    // entry [i][k] = k * 2^(6i) * 7919 mod p
    function automatic t_base_tab build_base_tab();
        t_base_tab   t;
        logic [63:0] w;
        logic [63:0] v;
        w = 64'd1;
        for (int i = 0; i < BASE_CHUNKS; i++) begin
            for (int k = 0; k < CHUNK_N; k++) begin
                v = (64'(k) * w) % MOD64;
                t[i][k] = HASH_W'((v * BASE64) % MOD64);
            end
            w = (w << CHUNK_W) % MOD64;
        end
        return t;
    endfunction

    // entry [i][k] = k * 2^(6i) mod p
    function automatic t_fold_tab build_fold_tab();
        t_fold_tab   t;
        logic [63:0] w;
        w = 64'd1;
        for (int i = 0; i < FOLD_CHUNKS; i++) begin
            for (int k = 0; k < CHUNK_N; k++) begin
                t[i][k] = HASH_W'((64'(k) * w) % MOD64);
            end
            w = (w << CHUNK_W) % MOD64;
        end
        return t;
    endfunction

    localparam t_base_tab BASE_TAB = build_base_tab();
    localparam t_fold_tab FOLD_TAB = build_fold_tab();

    // reduce a value below 8p to below p
    function automatic logic [HASH_W-1:0] mod_fold(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] r;
        r = x;
        for (int k = 1; k <= FOLD_STEPS; k++) begin
            if (x >= SUM_W'(k) * MOD_S) begin
                r = x - SUM_W'(k) * MOD_S;
            end
        end
        return r[HASH_W-1:0];
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] b, input logic on);
        logic [7:0] r;
        r = b;
        if (on && b >= CHAR_A && b <= CHAR_Z) begin
            r = b - CASE_GAP;
        end
        return r;
    endfunction

endpackage

FILE: design/rhm_hash_unit.sv
`timescale 1ns / 1ps
// rhm_hash_unit: pipelined rolling hash update and window compare
// uses rhm_pkg fold tables; fed from the window memory in the top level
module rhm_hash_unit
    import rhm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_clear,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [7:0]        i_old_byte,
    input  logic [HASH_W-1:0] i_top_power,
    input  logic [HASH_W-1:0] i_pattern_hash,
    output logic              o_valid,
    output t_side             o_side,
    output logic              o_match
);

    logic              r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid;
    t_side             r_a_side, r_b_side, r_c_side, r_d_side, r_e_side, r_f_side;
    logic              r_a_neg, r_b_neg, r_c_neg;
    logic [PROD_W-1:0] r_a_prod;
    logic [SUM_W-1:0]  r_b_sum;
    logic [HASH_W-1:0] r_c_rem;
    logic [HASH_W-1:0] r_d_c;
    logic [SUM_W-1:0]  r_e_h;
    logic [SUM_W-1:0]  r_h;
    logic              r_f_match;

    logic              old_neg;
    logic [7:0]        old_mag;
    logic [SUM_W-1:0]  n_b_sum;
    logic [SUM_W-1:0]  c_term;
    logic [SUM_W-1:0]  c_raw;
    logic [HX_W-1:0]   hx;
    logic [SUM_W-1:0]  n_h;

    // signed distance of the leaving byte from the bias
    always_comb begin
        old_neg = i_old_byte < BYTE_BIAS;
        old_mag = old_neg ? (BYTE_BIAS - i_old_byte) : (i_old_byte - BYTE_BIAS);
    end

    always_comb begin
        n_b_sum = '0;
        for (int i = 0; i < FOLD_CHUNKS; i++) begin
            n_b_sum = n_b_sum + SUM_W'(FOLD_TAB[i][r_a_prod[i*CHUNK_W +: CHUNK_W]]);
        end
    end

    always_comb begin
        c_term = '0;
        if (r_c_side.shift_out) begin
            c_term = r_c_neg ? SUM_W'(r_c_rem) : (MOD_S - SUM_W'(r_c_rem));
        end
        c_raw = SUM_W'(r_c_side.text_byte) + MOD_LESS_BIAS + c_term;
    end

    // hash loop: h * base folded through chunk tables, kept below 7p
    always_comb begin
        hx  = HX_W'(r_h);
        n_h = SUM_W'(r_d_c);
        for (int i = 0; i < BASE_CHUNKS; i++) begin
            n_h = n_h + SUM_W'(BASE_TAB[i][hx[i*CHUNK_W +: CHUNK_W]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_h       <= '0;
        end else begin
            if (i_en) begin
                r_a_valid <= i_valid;
                r_b_valid <= r_a_valid;
                r_c_valid <= r_b_valid;
                r_d_valid <= r_c_valid;
                r_e_valid <= r_d_valid;
                r_f_valid <= r_e_valid;
            end
            if (i_clear) begin
                r_h <= '0;
            end else if (i_en && r_d_valid) begin
                r_h <= r_d_side.last ? '0 : n_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side  <= i_side;
            r_a_neg   <= old_neg;
            r_a_prod  <= PROD_W'(old_mag) * PROD_W'(i_top_power);
            r_b_side  <= r_a_side;
            r_b_neg   <= r_a_neg;
            r_b_sum   <= n_b_sum;
            r_c_side  <= r_b_side;
            r_c_neg   <= r_b_neg;
            r_c_rem   <= mod_fold(r_b_sum);
            r_d_side  <= r_c_side;
            r_d_c     <= mod_fold(c_raw);
            r_e_side  <= r_d_side;
            r_e_h     <= n_h;
            r_f_side  <= r_e_side;
            r_f_match <= r_e_side.win_full && (mod_fold(r_e_h) == i_pattern_hash);
        end
    end

    assign o_valid = r_f_valid;
    assign o_side  = r_f_side;
    assign o_match = r_f_match;

endmodule

FILE: design/rolling_hash_match_uppercase.sv
`timescale 1ns / 1ps
// rolling_hash_match_uppercase: top level with window memory, front control,
// cover marking and end-of-text flush; uses rhm_pkg and rhm_hash_unit
//
//   channel   direction   handshake                    payload
//   in        sink        i_in_valid / o_in_stall      i_in_req  (t_in_req)
//   out       source      o_out_valid / i_out_stall    o_out_req (t_out_req)
//   cfg       sink        i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one request per cycle while o_in_stall is low; results pass s1, hash a-f and r_out
// the hash loop in rhm_hash_unit (table fold plus add) is what bounds that rate
// a last request blocks the input until its flush ends: pipeline drain plus one
// byte per unstalled cycle for each buffered byte, from the window memory's second port
// synchronous active-low reset; the window memory needs no clearing pass
// an output stall holds the pipeline and the input once an emitting result must wait
module rolling_hash_match_uppercase
    import rhm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_req               i_in_req,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_req              o_out_req,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W = LEN_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        r_rda;
    logic [7:0]        r_rdb;

    logic [HASH_W-1:0] r_phash;
    logic [HASH_W-1:0] r_tp;
    logic [LEN_W-1:0]  r_len;

    logic [LEN_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_wptr;
    logic [LEN_W-1:0]  r_flush_cnt;
    logic [ADDR_W-1:0] r_flush_addr;
    logic              r_hold;

    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic              r_s1_last;
    logic              r_s1_shift;
    logic              r_s1_win;
    logic              r_s1_emit;

    logic [LEN_W-1:0]  r_cover;
    logic              r_flushing;
    logic [LEN_W-1:0]  r_rem;
    logic [ADDR_W-1:0] r_raddr;
    logic              r_fq_v;
    logic              r_fq_last;

    logic              r_ovalid;
    t_out_req          r_out;

    logic              cfg_we;
    logic              len_we;
    logic [LEN_W-1:0]  n_len;
    logic [LEN_FIELD_W:0] len_raw;

    logic              acc;
    logic              adv;
    logic              bk_take;
    logic              out_free;
    logic              fq_go;
    logic              issue;
    logic              shift_out;
    logic [LEN_W-1:0]  fill_after;
    logic              win_full;

    t_side             s1_side;
    logic              u_valid;
    t_side             u_side;
    logic              u_match;
    logic [LEN_W-1:0]  cov_eff;
    logic [LEN_W-1:0]  n_cover;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign len_we      = cfg_we && (i_cfg_index == CFG_PATTERN_LENGTH);

    // length field (cfg data bits 5:0) 0 acts as 1, above the maximum as the maximum
    always_comb begin
        len_raw = {1'b0, i_cfg_data[LEN_FIELD_W-1:0]};
        if (len_raw == '0) begin
            n_len = LEN_W'(1);
        end else if (len_raw > (LEN_FIELD_W + 1)'(MAX_PATTERN)) begin
            n_len = LEN_W'(MAX_PATTERN);
        end else begin
            n_len = LEN_W'(len_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phash <= '0;
            r_len   <= LEN_W'(1);
            r_tp    <= HASH_BASE;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_HASH:   r_phash <= i_cfg_data[HASH_W-1:0];
                CFG_PATTERN_LENGTH: r_len   <= n_len;
                CFG_TOP_POWER:      r_tp    <= mod_fold(SUM_W'(i_cfg_data[HASH_W-1:0]));
                default: ;
            endcase
        end
    end

    // handshake and pipeline advance
    assign out_free   = !r_ovalid || !i_out_stall;
    assign bk_take    = !r_flushing && (!u_side.emit || out_free);
    assign adv        = !u_valid || bk_take;
    assign o_in_stall = !adv || r_hold;
    assign acc        = i_in_valid && !o_in_stall;
    assign fq_go      = r_fq_v && out_free;
    assign issue      = r_flushing && (r_rem != '0) && (!r_fq_v || fq_go);

    // front control
    assign shift_out  = (r_fill == r_len);
    assign fill_after = shift_out ? r_len : (r_fill + LEN_W'(1));
    assign win_full   = (fill_after == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_wptr     <= '0;
            r_hold     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (len_we) begin
                r_fill <= '0;
            end else if (acc) begin
                r_fill <= i_in_req.text_last ? '0 : fill_after;
            end
            if (acc) begin
                r_wptr <= r_wptr + ADDR_W'(1);
            end
            if (acc && i_in_req.text_last) begin
                r_hold <= 1'b1;
            end else if (fq_go && r_fq_last) begin
                r_hold <= 1'b0;
            end
            if (adv) begin
                r_s1_valid <= acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_byte  <= i_in_req.text_byte;
            r_s1_last  <= i_in_req.text_last;
            r_s1_shift <= shift_out;
            r_s1_win   <= win_full;
            r_s1_emit  <= win_full && !i_in_req.text_last;
        end
        if (acc && i_in_req.text_last) begin
            r_flush_cnt  <= fill_after;
            r_flush_addr <= r_wptr - ADDR_W'(fill_after) + ADDR_W'(1);
        end
    end

    // window memory: one write, two reads
    always_ff @(posedge i_clk) begin
        if (acc) begin
            mem[r_wptr] <= i_in_req.text_byte;
            r_rda       <= mem[r_wptr - ADDR_W'(r_len)];
        end
        if (acc) begin
            r_rdb <= mem[r_wptr - ADDR_W'(r_len) + ADDR_W'(1)];
        end else if (issue) begin
            r_rdb <= mem[r_raddr];
        end
    end

    always_comb begin
        s1_side.text_byte = r_s1_byte;
        s1_side.emit_byte = (r_len == LEN_W'(1)) ? r_s1_byte : r_rdb;
        s1_side.shift_out = r_s1_shift;
        s1_side.win_full  = r_s1_win;
        s1_side.emit      = r_s1_emit;
        s1_side.last      = r_s1_last;
    end

    rhm_hash_unit u_hash (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_clear        (len_we),
        .i_valid        (r_s1_valid),
        .i_side         (s1_side),
        .i_old_byte     (r_rda),
        .i_top_power    (r_tp),
        .i_pattern_hash (r_phash),
        .o_valid        (u_valid),
        .o_side         (u_side),
        .o_match        (u_match)
    );

    // cover marking
    assign cov_eff = u_match ? r_len : r_cover;

    always_comb begin
        n_cover = cov_eff;
        if (u_side.emit && (cov_eff != '0)) begin
            n_cover = cov_eff - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cover    <= '0;
            r_flushing <= 1'b0;
            r_fq_v     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (len_we) begin
                r_cover <= '0;
            end else if (u_valid && bk_take) begin
                r_cover <= n_cover;
            end else if (fq_go) begin
                if (r_fq_last) begin
                    r_cover <= '0;
                end else if (r_cover != '0) begin
                    r_cover <= r_cover - LEN_W'(1);
                end
            end

            if (u_valid && bk_take && u_side.last) begin
                r_flushing <= 1'b1;
            end else if (fq_go && r_fq_last) begin
                r_flushing <= 1'b0;
            end

            if (issue) begin
                r_fq_v <= 1'b1;
            end else if (fq_go) begin
                r_fq_v <= 1'b0;
            end

            if ((u_valid && bk_take && u_side.emit) || fq_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (u_valid && bk_take && u_side.last) begin
            r_rem   <= r_flush_cnt;
            r_raddr <= r_flush_addr;
        end else if (issue) begin
            r_rem   <= r_rem - LEN_W'(1);
            r_raddr <= r_raddr + ADDR_W'(1);
        end
        if (issue) begin
            r_fq_last <= (r_rem == LEN_W'(1));
        end
        if (u_valid && bk_take && u_side.emit) begin
            r_out.out_byte <= upcase(u_side.emit_byte, cov_eff != '0);
            r_out.out_last <= 1'b0;
        end else if (fq_go) begin
            r_out.out_byte <= upcase(r_rdb, r_cover != '0);
            r_out.out_last <= r_fq_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_req   = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("fill count above window length");

    a_cover_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cover <= r_len)
        else $error("cover count above window length");

    a_flush_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> !u_valid)
        else $error("request behind a flushing text");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_req.text_last) |=> r_hold)
        else $error("input not held after last request");

    a_pending_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fq_v |-> r_flushing)
        else $error("flush byte pending outside a flush");

endmodule
